>>> hdl/dpbm_pkg.sv
package dpbm_pkg;

  localparam int unsigned VIRTUAL_PAGES   = 16;
  localparam int unsigned PAGE_BYTES      = 4096;
  localparam int unsigned PHYSICAL_FRAMES = 16;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
  localparam int unsigned VPN_W   = $clog2(VIRTUAL_PAGES);
  localparam int unsigned FRAME_W = $clog2(PHYSICAL_FRAMES);
  localparam int unsigned STORE_BYTES = 1 << ADDR_W;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_SKIPPED  = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [ADDR_W-1:0]   virtual_address;
    logic [DATA_W-1:0]   write_data;
    logic                last_of_access;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                ok;
    status_e             status;
    logic                done_of_access;
  } rsp_t;

endpackage

>>> hdl/demand_paged_byte_memory_core.sv
// A transaction taken at one edge has its result on rsp_o in the cycle after, with
// rsp_valid_o high for a single cycle; one transaction may be taken every cycle.
// The result strobe cannot be stalled by the receiver. Start is ignored while busy.
// Reset clears the page table, the frame map and the failure flag at once, then sweeps
// the 65536-byte store to zero, one byte a cycle, with busy high until the sweep ends.
// Configuration writes are taken on every cycle, also during the sweep.
module demand_paged_byte_memory_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  dpbm_pkg::req_t                req_i,
  output logic                          rsp_valid_o,
  output dpbm_pkg::rsp_t                rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dpbm_pkg::CFG_W-1:0]    cfg_data_i
);
  import dpbm_pkg::*;

  // control and mapping state
  logic [CFG_W-1:0]           frames_q;
  logic                       failed_q, failed_d;
  logic [VIRTUAL_PAGES-1:0]   page_valid_q, page_valid_d;
  logic [FRAME_W-1:0]         page_frame_q [VIRTUAL_PAGES];
  logic [PHYSICAL_FRAMES-1:0] frame_used_q, frame_used_d;
  logic                       clr_active_q;
  logic [ADDR_W-1:0]          clr_addr_q;

  // result registers
  logic                       rsp_valid_q;
  logic                       rd_ok_q;
  logic                       ok_q;
  status_e                    status_q;
  logic                       done_q;

  // store
  logic [DATA_W-1:0]          store_mem [STORE_BYTES];
  logic [DATA_W-1:0]          mem_rdata_q;

  logic                       accept;
  logic [VPN_W-1:0]           vpn;
  logic [OFF_W-1:0]           offset;
  logic [FRAME_W:0]           limit;
  logic                       free_found;
  logic [FRAME_W-1:0]         free_frame;
  logic [FRAME_W-1:0]         frame_sel;
  logic [ADDR_W-1:0]          phys_addr;
  logic                       alloc;
  logic                       item_we;
  logic                       item_ok;
  logic                       item_rd_ok;
  status_e                    item_status;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [DATA_W-1:0]          mem_wdata;

  assign accept      = start && !clr_active_q;
  assign busy        = clr_active_q;
  assign cfg_ready_o = 1'b1;

  assign vpn    = req_i.virtual_address[OFF_W +: VPN_W];
  assign offset = req_i.virtual_address[OFF_W-1:0];

  // clamp the frame limit to the frames that exist
  assign limit = (frames_q > CFG_W'(PHYSICAL_FRAMES)) ? (FRAME_W+1)'(PHYSICAL_FRAMES)
                                                      : (FRAME_W+1)'(frames_q);

  // lowest free frame below the limit
  always_comb begin
    free_found = 1'b0;
    free_frame = '0;
    for (int i = 0; i < PHYSICAL_FRAMES; i++) begin
      if (!free_found && !frame_used_q[i] && ((FRAME_W+1)'(i) < limit)) begin
        free_found = 1'b1;
        free_frame = FRAME_W'(i);
      end
    end
  end

  always_comb begin
    alloc       = 1'b0;
    item_we     = 1'b0;
    item_ok     = 1'b0;
    item_rd_ok  = 1'b0;
    item_status = ST_DONE;
    frame_sel   = page_frame_q[vpn];
    if (failed_q) begin
      item_status = ST_SKIPPED;
    end else if (req_i.opcode == OP_READ) begin
      if (page_valid_q[vpn]) begin
        item_ok    = 1'b1;
        item_rd_ok = 1'b1;
      end else begin
        item_status = ST_UNMAPPED;
      end
    end else begin
      if (page_valid_q[vpn]) begin
        item_ok = 1'b1;
        item_we = 1'b1;
      end else if (free_found) begin
        alloc     = 1'b1;
        item_ok   = 1'b1;
        item_we   = 1'b1;
        frame_sel = free_frame;
      end else begin
        item_status = ST_NO_FRAME;
      end
    end
  end

  assign phys_addr = ADDR_W'({frame_sel, offset});

  always_comb begin
    page_valid_d = page_valid_q;
    frame_used_d = frame_used_q;
    failed_d     = failed_q;
    if (accept) begin
      if (alloc) begin
        page_valid_d[vpn]        = 1'b1;
        frame_used_d[free_frame] = 1'b1;
      end
      if (item_status == ST_UNMAPPED || item_status == ST_NO_FRAME) begin
        failed_d = 1'b1;
      end
      if (req_i.last_of_access) begin
        failed_d = 1'b0;
      end
    end
  end

  // one write port shared by the reset sweep and the transactions
  always_comb begin
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && item_we;
      mem_waddr = phys_addr;
      mem_wdata = req_i.write_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= store_mem[phys_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q     <= FRAMES_RESET;
      failed_q     <= 1'b0;
      page_valid_q <= '0;
      frame_used_q <= '0;
      for (int i = 0; i < VIRTUAL_PAGES; i++) begin
        page_frame_q[i] <= '0;
      end
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        frames_q <= cfg_data_i;
      end
      failed_q     <= failed_d;
      page_valid_q <= page_valid_d;
      frame_used_q <= frame_used_d;
      if (accept && alloc) begin
        page_frame_q[vpn] <= free_frame;
      end
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      rsp_valid_q <= accept;
    end
  end

  // hold the result fields for the strobe cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ok_q  <= item_rd_ok;
      ok_q     <= item_ok;
      status_q <= item_status;
      done_q   <= req_i.last_of_access;
    end
  end

  assign rsp_valid_o           = rsp_valid_q;
  assign rsp_o.read_data       = rd_ok_q ? mem_rdata_q : '0;
  assign rsp_o.ok              = ok_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.done_of_access  = done_q;

endmodule
